/* hw/rtl/setpoint_step_and_yaw_limiter_core_macros.svh */
// Assertion macros shared by the setpoint limiter RTL.
`ifndef SETPOINT_STEP_AND_YAW_LIMITER_CORE_MACROS_SVH
`define SETPOINT_STEP_AND_YAW_LIMITER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSYL_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSYL_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ssyl_pkg.sv */
// Types and constants of the setpoint step and yaw limiter.
package ssyl_pkg;

  localparam int POS_BITS   = 24;
  localparam int NAX        = 3;
  localparam int ANG_W      = 16;
  localparam int STEP_W     = 16;
  localparam int YAW_STEP_W = 15;
  localparam int D_W        = POS_BITS + 1;
  localparam int MAG_W      = POS_BITS + 1;
  localparam int SQ_W       = 2 * POS_BITS + 1;
  localparam int SUM_W      = 2 * POS_BITS + 2;
  localparam int ROOT_W     = POS_BITS + 1;
  localparam int QUO_W      = STEP_W;
  localparam int PROD_W     = MAG_W + STEP_W;
  localparam int RES_W      = POS_BITS + 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_YAW  = CFG_IDX_W'(1);

  localparam logic [STEP_W-1:0]     MAX_STEP_RST = STEP_W'(1200);
  localparam logic [YAW_STEP_W-1:0] MAX_YAW_RST  = YAW_STEP_W'(3129);

  typedef struct packed {
    logic signed [POS_BITS-1:0] current_x;
    logic signed [POS_BITS-1:0] current_y;
    logic signed [POS_BITS-1:0] current_z;
    logic signed [ANG_W-1:0]    cur_heading;
    logic signed [POS_BITS-1:0] target_x;
    logic signed [POS_BITS-1:0] target_y;
    logic signed [POS_BITS-1:0] target_z;
    logic signed [ANG_W-1:0]    tgt_heading;
  } req_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] out_x;
    logic signed [POS_BITS-1:0] out_y;
    logic signed [POS_BITS-1:0] out_z;
    logic signed [ANG_W-1:0]    out_yaw;
    logic                       step_limited;
    logic                       yaw_limited;
  } rsp_t;

endpackage

/* hw/rtl/setpoint_step_and_yaw_limiter_core.sv */
// Setpoint step and yaw limiter: pipelined top level.
//
// Usage:
//   req channel (req_valid, req_stall, req) carries a current and a target
//   pose; a transfer happens at a clock edge with req_valid high and
//   req_stall low. rsp channel (rsp_valid, rsp_stall, rsp) returns one
//   limited setpoint per request, in order.
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
//   max_step_mm (index 0) and max_yaw_step (index 1); cfg_ready is always
//   high. Write only while no request is in flight. Other indexes are dropped.
// Timing:
//   From request transfer to rsp_valid a request passes three front stages
//   (difference, squares, sum), one stage per root bit of the square root,
//   one multiply stage, one stage per quotient bit of the step scaling, and
//   the output register. Throughput is one item per cycle while rsp_stall
//   does not hold the pipeline.
// Reset (rst, synchronous): empties the pipeline and reloads the limits
//   (1200 mm, 3129 angle units).
// Stall: while rsp_valid and rsp_stall are both high the whole pipeline
//   holds and req_stall is raised; no item is lost or repeated.
`include "setpoint_step_and_yaw_limiter_core_macros.svh"

module setpoint_step_and_yaw_limiter_core
  import ssyl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic signed [RES_W-1:0] RES_HI =
    RES_W'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
  localparam logic signed [RES_W-1:0] RES_LO = -RES_HI - RES_W'(1);

  // Configuration registers.
  logic [STEP_W-1:0]     max_step;
  logic [YAW_STEP_W-1:0] max_yaw;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_step <= MAX_STEP_RST;
      max_yaw  <= MAX_YAW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_STEP: max_step <= cfg_data;
        REG_MAX_YAW:  max_yaw  <= cfg_data[YAW_STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together; hold everything only when the
  // output register is full and the receiver stalls.
  logic en;
  assign en        = !(rsp_valid && rsp_stall);
  assign req_stall = !en;

  // Front stage: unpack, offsets and their magnitudes, yaw clamp.
  logic signed [POS_BITS-1:0] in_cur [NAX];
  logic signed [POS_BITS-1:0] in_tgt [NAX];
  logic signed [D_W-1:0]      in_d   [NAX];
  logic [ANG_W-1:0]           yaw_next;
  logic                       ylim_next;
  logic signed [ANG_W:0]      ydiff_x;
  logic signed [ANG_W:0]      ylim_x;
  logic [ANG_W-1:0]           ydiff;
  logic [ANG_W-1:0]           ystep;

  always_comb begin
    in_cur[0] = req.current_x;
    in_cur[1] = req.current_y;
    in_cur[2] = req.current_z;
    in_tgt[0] = req.target_x;
    in_tgt[1] = req.target_y;
    in_tgt[2] = req.target_z;
    for (int i = 0; i < NAX; i++) begin
      in_d[i] = D_W'(in_tgt[i]) - D_W'(in_cur[i]);
    end
    // Wrap the heading difference as a binary angle, then clamp it.
    ydiff   = req.tgt_heading - req.cur_heading;
    ydiff_x = {ydiff[ANG_W-1], ydiff};
    ylim_x  = (ANG_W + 1)'({2'b00, max_yaw});
    ystep   = ydiff;
    ylim_next = 1'b0;
    if (ydiff_x > ylim_x) begin
      ystep     = ylim_x[ANG_W-1:0];
      ylim_next = 1'b1;
    end else if (ydiff_x < -ylim_x) begin
      ystep     = ANG_W'(-ylim_x);
      ylim_next = 1'b1;
    end
    yaw_next = req.cur_heading + ystep;
  end

  logic                       a_v;
  logic signed [POS_BITS-1:0] a_cur [NAX];
  logic signed [POS_BITS-1:0] a_tgt [NAX];
  logic                       a_neg [NAX];
  logic [MAG_W-1:0]           a_mag [NAX];
  logic [ANG_W-1:0]           a_yaw;
  logic                       a_ylim;

  // Squares stage.
  logic                       b_v;
  logic signed [POS_BITS-1:0] b_cur [NAX];
  logic signed [POS_BITS-1:0] b_tgt [NAX];
  logic                       b_neg [NAX];
  logic [MAG_W-1:0]           b_mag [NAX];
  logic [SQ_W-1:0]            b_sq  [NAX];
  logic [ANG_W-1:0]           b_yaw;
  logic                       b_ylim;

  // Square root stages: entry 0 holds the sum, entry k+1 has decided bit
  // ROOT_W-1-k of the root. s_rem is the sum minus the square of s_root.
  logic                       s_v    [0:ROOT_W];
  logic [SUM_W-1:0]           s_rem  [0:ROOT_W];
  logic [ROOT_W-1:0]          s_root [0:ROOT_W];
  logic signed [POS_BITS-1:0] s_cur  [0:ROOT_W][NAX];
  logic signed [POS_BITS-1:0] s_tgt  [0:ROOT_W][NAX];
  logic                       s_neg  [0:ROOT_W][NAX];
  logic [MAG_W-1:0]           s_mag  [0:ROOT_W][NAX];
  logic [ANG_W-1:0]           s_yaw  [0:ROOT_W];
  logic                       s_ylim [0:ROOT_W];
  logic [SUM_W-1:0]           s_rem_next  [0:ROOT_W-1];
  logic [ROOT_W-1:0]          s_root_next [0:ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    localparam int B = ROOT_W - 1 - k;
    logic [SUM_W:0] trial;
    logic           take;
    assign trial = ((SUM_W + 1)'(s_root[k]) << (B + 1)) | ((SUM_W + 1)'(1) << (2 * B));
    assign take  = {1'b0, s_rem[k]} >= trial;
    assign s_rem_next[k]  = take ? s_rem[k] - trial[SUM_W-1:0] : s_rem[k];
    assign s_root_next[k] = s_root[k] | (ROOT_W'(take) << B);
  end

  // Division stages: entry 0 holds |d| * max_step, entry k+1 has decided
  // quotient bit QUO_W-1-k. When the step is limited the quotient never exceeds max_step.
  logic                       q_v    [0:QUO_W];
  logic                       q_lim  [0:QUO_W];
  logic [ROOT_W-1:0]          q_dist [0:QUO_W];
  logic signed [POS_BITS-1:0] q_cur  [0:QUO_W][NAX];
  logic signed [POS_BITS-1:0] q_tgt  [0:QUO_W][NAX];
  logic                       q_neg  [0:QUO_W][NAX];
  logic [PROD_W-1:0]          q_rem  [0:QUO_W][NAX];
  logic [QUO_W-1:0]           q_quo  [0:QUO_W][NAX];
  logic [ANG_W-1:0]           q_yaw  [0:QUO_W];
  logic                       q_ylim [0:QUO_W];
  logic [PROD_W-1:0]          q_rem_next [0:QUO_W-1][NAX];
  logic [QUO_W-1:0]           q_quo_next [0:QUO_W-1][NAX];

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int J = QUO_W - 1 - k;
    for (genvar i = 0; i < NAX; i++) begin : g_ax
      logic [PROD_W-1:0] shifted;
      logic              take;
      assign shifted = PROD_W'(q_dist[k]) << J;
      assign take    = q_rem[k][i] >= shifted;
      assign q_rem_next[k][i] = take ? q_rem[k][i] - shifted : q_rem[k][i];
      assign q_quo_next[k][i] = q_quo[k][i] | (QUO_W'(take) << J);
    end
  end

  // Output stage: apply the scaled step, or pass the target, and saturate.
  logic signed [POS_BITS-1:0] out_pos [NAX];

  always_comb begin
    logic signed [RES_W-1:0] qs;
    logic signed [RES_W-1:0] sum;
    for (int i = 0; i < NAX; i++) begin
      qs  = q_neg[QUO_W][i] ? -RES_W'(q_quo[QUO_W][i]) : RES_W'(q_quo[QUO_W][i]);
      sum = RES_W'(q_cur[QUO_W][i]) + qs;
      if (!q_lim[QUO_W]) begin
        out_pos[i] = q_tgt[QUO_W][i];
      end else if (sum > RES_HI) begin
        out_pos[i] = RES_HI[POS_BITS-1:0];
      end else if (sum < RES_LO) begin
        out_pos[i] = RES_LO[POS_BITS-1:0];
      end else begin
        out_pos[i] = sum[POS_BITS-1:0];
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      s_v       <= '{default: 1'b0};
      q_v       <= '{default: 1'b0};
      rsp_valid <= 1'b0;
    end else if (en) begin
      a_v  <= req_valid;
      b_v  <= a_v;
      s_v[0] <= b_v;
      for (int k = 0; k < ROOT_W; k++) begin
        s_v[k+1] <= s_v[k];
      end
      q_v[0] <= s_v[ROOT_W];
      for (int k = 0; k < QUO_W; k++) begin
        q_v[k+1] <= q_v[k];
      end
      rsp_valid <= q_v[QUO_W];
    end
  end

  // Payload: advance every stage together.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NAX; i++) begin
        a_cur[i] <= in_cur[i];
        a_tgt[i] <= in_tgt[i];
        a_neg[i] <= in_d[i][D_W-1];
        a_mag[i] <= in_d[i][D_W-1] ? MAG_W'(-in_d[i]) : MAG_W'(in_d[i]);
        b_cur[i] <= a_cur[i];
        b_tgt[i] <= a_tgt[i];
        b_neg[i] <= a_neg[i];
        b_mag[i] <= a_mag[i];
        b_sq[i]  <= SQ_W'(a_mag[i]) * SQ_W'(a_mag[i]);
        s_cur[0][i] <= b_cur[i];
        s_tgt[0][i] <= b_tgt[i];
        s_neg[0][i] <= b_neg[i];
        s_mag[0][i] <= b_mag[i];
      end
      a_yaw  <= yaw_next;
      a_ylim <= ylim_next;
      b_yaw  <= a_yaw;
      b_ylim <= a_ylim;

      s_rem[0]  <= SUM_W'(b_sq[0]) + SUM_W'(b_sq[1]) + SUM_W'(b_sq[2]);
      s_root[0] <= '0;
      s_yaw[0]  <= b_yaw;
      s_ylim[0] <= b_ylim;
      for (int k = 0; k < ROOT_W; k++) begin
        s_rem[k+1]  <= s_rem_next[k];
        s_root[k+1] <= s_root_next[k];
        s_yaw[k+1]  <= s_yaw[k];
        s_ylim[k+1] <= s_ylim[k];
        for (int i = 0; i < NAX; i++) begin
          s_cur[k+1][i] <= s_cur[k][i];
          s_tgt[k+1][i] <= s_tgt[k][i];
          s_neg[k+1][i] <= s_neg[k][i];
          s_mag[k+1][i] <= s_mag[k][i];
        end
      end

      q_lim[0]  <= s_root[ROOT_W] > ROOT_W'(max_step);
      q_dist[0] <= s_root[ROOT_W];
      q_yaw[0]  <= s_yaw[ROOT_W];
      q_ylim[0] <= s_ylim[ROOT_W];
      for (int i = 0; i < NAX; i++) begin
        q_cur[0][i] <= s_cur[ROOT_W][i];
        q_tgt[0][i] <= s_tgt[ROOT_W][i];
        q_neg[0][i] <= s_neg[ROOT_W][i];
        q_rem[0][i] <= PROD_W'(s_mag[ROOT_W][i]) * PROD_W'(max_step);
        q_quo[0][i] <= '0;
      end
      for (int k = 0; k < QUO_W; k++) begin
        q_lim[k+1]  <= q_lim[k];
        q_dist[k+1] <= q_dist[k];
        q_yaw[k+1]  <= q_yaw[k];
        q_ylim[k+1] <= q_ylim[k];
        for (int i = 0; i < NAX; i++) begin
          q_cur[k+1][i] <= q_cur[k][i];
          q_tgt[k+1][i] <= q_tgt[k][i];
          q_neg[k+1][i] <= q_neg[k][i];
          q_rem[k+1][i] <= q_rem_next[k][i];
          q_quo[k+1][i] <= q_quo_next[k][i];
        end
      end

      rsp.out_x        <= out_pos[0];
      rsp.out_y        <= out_pos[1];
      rsp.out_z        <= out_pos[2];
      rsp.out_yaw      <= q_yaw[QUO_W];
      rsp.step_limited <= q_lim[QUO_W];
      rsp.yaw_limited  <= q_ylim[QUO_W];
    end
  end

  // Assertions.
  `SSYL_HOLDS(a_stall_holds_input, clk, rst, rsp_valid && rsp_stall, req_stall,
    "input taken while the output is stalled")
  `SSYL_NEXT(a_transfer_enters, clk, rst, req_valid && !req_stall, a_v,
    "accepted request did not enter the pipeline")
  `SSYL_HOLDS(a_root_is_floor, clk, rst, s_v[ROOT_W],
    s_rem[ROOT_W] <= (SUM_W'(s_root[ROOT_W]) << 1),
    "square root remainder too large")
  `SSYL_HOLDS(a_quotient_bound, clk, rst, q_v[QUO_W] && q_lim[QUO_W],
    q_quo[QUO_W][0] <= max_step && q_quo[QUO_W][1] <= max_step && q_quo[QUO_W][2] <= max_step,
    "scaled step exceeds the step limit")

endmodule
